// ===== rtl/core/rhc_pkg.sv =====
package rhc_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned SumW    = 9;
  localparam int unsigned HueW    = 15;
  localparam int unsigned NumW    = 20;
  localparam int unsigned QuoW    = 12;
  localparam int unsigned HueSpan = 3840;
  localparam int unsigned HueSect = 7680;
  localparam int unsigned HueFull = 23040;
  localparam int unsigned ChanMax = 255;

  typedef enum logic [1:0] {
    SECT_RED   = 2'd0,
    SECT_GREEN = 2'd1,
    SECT_BLUE  = 2'd2
  } sector_e;

  typedef struct packed {
    logic              valid;
    logic              achrom;
    logic              neg;
    sector_e           sector;
    logic [SumW-1:0]   lsum;
    logic [NumW-1:0]   num_h;
    logic [ChanW-1:0]  den_h;
    logic [QuoW-1:0]   quo_h;
    logic [NumW-1:0]   num_s;
    logic [SumW-1:0]   den_s;
    logic [QuoW-1:0]   quo_s;
  } stage_t;

endpackage

// ===== rtl/core/rhc_in_if.sv =====
interface rhc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ===== rtl/core/rhc_out_if.sv =====
interface rhc_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] hue;
  logic [7:0]  saturation;
  logic [8:0]  lightness_sum;

  modport source (output valid, output hue, output saturation, output lightness_sum,
                  input ready);
  modport sink (input valid, input hue, input saturation, input lightness_sum,
                output ready);
endinterface

// ===== rtl/core/rgb_to_hsl_converter_unit.sv =====
// RGB to HSL converter: accepts one 8-bit RGB pixel per clock unless stalled and returns hue
// (1/64 degree), saturation (scaled by 255) and max+min. A front cell finds max, min and
// sector, a chain of twelve identical restoring-division cells each resolves one quotient
// bit for hue and saturation, and an output register closes the pipeline.
// The whole pipeline advances together; it stalls only when the output register is full
// and not taken.
module rgb_to_hsl_converter_unit (
  input  logic clk_i,
  input  logic rst_ni,
  rhc_in_if.sink    in_i,
  rhc_out_if.source out_o
);
  import rhc_pkg::*;

  logic              en;
  stage_t            st [QuoW+1];
  logic              valid_q;
  logic [HueW-1:0]   hue_d, hue_q;
  logic [ChanW-1:0]  sat_d, sat_q;
  logic [SumW-1:0]   lsum_q;
  logic signed [HueW+1:0] off, hs;

  assign en       = !valid_q || out_o.ready;
  assign in_i.ready = en;

  rhc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .red_i   (in_i.red),
    .green_i (in_i.green),
    .blue_i  (in_i.blue),
    .stage_o (st[0])
  );

  for (genvar k = 0; k < QuoW; k++) begin : g_cell
    rhc_div_cell #(.Bit(QuoW - 1 - k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .stage_i (st[k]),
      .stage_o (st[k+1])
    );
  end

  always_comb begin
    case (st[QuoW].sector)
      SECT_GREEN: off = (HueW+2)'(HueSect);
      SECT_BLUE:  off = (HueW+2)'(2 * HueSect);
      default:    off = '0;
    endcase
    if (st[QuoW].neg) hs = off - $signed({5'b0, st[QuoW].quo_h});
    else              hs = off + $signed({5'b0, st[QuoW].quo_h});
    if (hs < 0) hs = hs + (HueW+2)'(HueFull);
    hue_d = st[QuoW].achrom ? '0 : hs[HueW-1:0];
    sat_d = st[QuoW].achrom ? '0 : st[QuoW].quo_s[ChanW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= st[QuoW].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hue_q  <= hue_d;
      sat_q  <= sat_d;
      lsum_q <= st[QuoW].lsum;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.hue           = hue_q;
  assign out_o.saturation    = sat_q;
  assign out_o.lightness_sum = lsum_q;

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q |-> in_i.ready)
    else $error("input stalled with empty output");
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> hue_q < HueW'(HueFull))
    else $error("hue out of range");
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !out_o.ready |=> valid_q && $stable(hue_q) && $stable(sat_q))
    else $error("result changed under stall");
  a_achrom_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && st[QuoW].valid && st[QuoW].achrom |=> sat_q == '0 && hue_q == '0)
    else $error("achromatic pixel with nonzero hue or saturation");
`endif
endmodule

// ===== rtl/core/rhc_front.sv =====
module rhc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [7:0]            red_i,
  input  logic [7:0]            green_i,
  input  logic [7:0]            blue_i,
  output rhc_pkg::stage_t       stage_o
);
  import rhc_pkg::*;

  logic [ChanW-1:0] mx, mn, delta, absd;
  logic [SumW-1:0]  sum, den;
  logic signed [SumW:0] diff;
  logic [NumW-1:0]  mag;
  sector_e          sect;
  stage_t           stage_d, stage_q;

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    sum   = {1'b0, mx} + {1'b0, mn};
    delta = mx - mn;
    den   = (sum <= SumW'(ChanMax)) ? sum : SumW'(2 * ChanMax) - sum;
    if (red_i == mx) begin
      sect = SECT_RED;
      diff = $signed({2'b00, green_i}) - $signed({2'b00, blue_i});
    end else if (green_i == mx) begin
      sect = SECT_GREEN;
      diff = $signed({2'b00, blue_i}) - $signed({2'b00, red_i});
    end else begin
      sect = SECT_BLUE;
      diff = $signed({2'b00, red_i}) - $signed({2'b00, green_i});
    end
    absd = diff[SumW] ? ChanW'(-diff) : ChanW'(diff);
    mag  = NumW'(HueSpan) * NumW'(absd);

    stage_d.valid  = valid_i;
    stage_d.achrom = (delta == '0);
    stage_d.neg    = diff[SumW];
    stage_d.sector = sect;
    stage_d.lsum   = sum;
    stage_d.num_h  = diff[SumW] ? mag + NumW'(delta) - NumW'(1) : mag;
    stage_d.den_h  = (delta == '0) ? ChanW'(1) : delta;
    stage_d.quo_h  = '0;
    stage_d.num_s  = NumW'(ChanMax) * NumW'(delta);
    stage_d.den_s  = (delta == '0) ? SumW'(1) : den;
    stage_d.quo_s  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;
endmodule

// ===== rtl/core/rhc_div_cell.sv =====
module rhc_div_cell #(
  parameter int unsigned Bit = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  rhc_pkg::stage_t stage_i,
  output rhc_pkg::stage_t stage_o
);
  import rhc_pkg::*;

  logic [NumW:0] sh_h, sh_s;
  stage_t        stage_d, stage_q;

  always_comb begin
    sh_h = (NumW+1)'(stage_i.den_h) << Bit;
    sh_s = (NumW+1)'(stage_i.den_s) << Bit;
    stage_d = stage_i;
    if ({1'b0, stage_i.num_h} >= sh_h) begin
      stage_d.num_h      = stage_i.num_h - sh_h[NumW-1:0];
      stage_d.quo_h[Bit] = 1'b1;
    end
    if ({1'b0, stage_i.num_s} >= sh_s) begin
      stage_d.num_s      = stage_i.num_s - sh_s[NumW-1:0];
      stage_d.quo_s[Bit] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;
endmodule
